>>> hw/rtl/tlbpt_pkg.sv
package tlbpt_pkg;

  localparam int unsigned TlbEntries  = 16;
  localparam int unsigned PageCount   = 256;
  localparam int unsigned FrameCount  = 64;
  localparam int unsigned OffsetWidth = 8;

  localparam int unsigned AddrW = 16;
  localparam int unsigned PaW   = 14;
  localparam int unsigned EvW   = 8;

  localparam logic PolicyFifo = 1'b0;
  localparam logic PolicyLru  = 1'b1;

endpackage

>>> hw/rtl/tlb_page_table_translator_unit.sv
// Channel  | Ports                                          | Handshake
// command  | start_i, logical_address_i, busy_o             | taken when start_i && !busy_o
// result   | done_o, phys_addr_o, tlb_hit_o, ...            | one-cycle strobe, no stall
// config   | policy_we_i, policy_wdata_i                    | written when policy_we_i
//
// A word goes through a two-deep command queue into the translation sequencer.
// Sequencer paths per word: TLB hit goes LOOK, DONE; table hit or free frame goes
// LOOK, PT, DONE; FIFO victim goes LOOK, PT, VICT, ORD, OWN, DONE; LRU victim adds
// the serial stamp sweep (S_LRU) over all frames before VICT.
// Reset (rst_ni low) clears valid bits (stamp valid bits too), pointers, counters.
// busy_o rises only while the command queue is full; results are not stalled.
module tlb_page_table_translator_unit import tlbpt_pkg::*; #(
  parameter int unsigned TLB_ENTRIES  = TlbEntries,
  parameter int unsigned PAGE_COUNT   = PageCount,
  parameter int unsigned FRAME_COUNT  = FrameCount,
  parameter int unsigned OFFSET_WIDTH = OffsetWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AddrW-1:0] logical_address_i,
  output logic             busy_o,
  input  logic             policy_we_i,
  input  logic             policy_wdata_i,
  output logic             done_o,
  output logic [PaW-1:0]   phys_addr_o,
  output logic             tlb_hit_o,
  output logic             page_fault_o,
  output logic             evicted_valid_o,
  output logic [EvW-1:0]   evicted_page_o
);

  logic             policy_q;
  logic             qv, qpop;
  logic [AddrW-1:0] qaddr;

  // replacement policy register: 0 FIFO, 1 LRU
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) policy_q <= PolicyFifo;
    else if (policy_we_i) policy_q <= policy_wdata_i;
  end

  tlbpt_front #(.AW(AddrW)) u_front (
    .clk_i, .rst_ni, .start_i, .logical_address_i, .busy_o,
    .q_valid_o(qv), .q_addr_o(qaddr), .q_pop_i(qpop)
  );

  tlbpt_back #(
    .TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
    .FRAME_COUNT(FRAME_COUNT), .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_back (
    .clk_i, .rst_ni, .policy_i(policy_q),
    .q_valid_i(qv), .q_addr_i(qaddr), .q_pop_o(qpop),
    .done_o, .phys_addr_o, .tlb_hit_o, .page_fault_o,
    .evicted_valid_o, .evicted_page_o
  );

endmodule

>>> hw/rtl/tlbpt_front.sv
// Front end: command capture into a two-deep word queue.
module tlbpt_front import tlbpt_pkg::*; #(
  parameter int unsigned AW = AddrW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] logical_address_i,
  output logic          busy_o,
  output logic          q_valid_o,
  output logic [AW-1:0] q_addr_o,
  input  logic          q_pop_i
);

  logic [AW-1:0] slot_q [2];
  logic [1:0]    cnt_q, cnt_d;
  logic          rd_q, wr_q;
  logic          push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_addr_o  = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i && q_valid_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i && q_valid_o) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= logical_address_i;
  end

endmodule

>>> hw/rtl/tlbpt_back.sv
// Back end: translation sequencer.
module tlbpt_back import tlbpt_pkg::*; #(
  parameter int unsigned TLB_ENTRIES  = TlbEntries,
  parameter int unsigned PAGE_COUNT   = PageCount,
  parameter int unsigned FRAME_COUNT  = FrameCount,
  parameter int unsigned OFFSET_WIDTH = OffsetWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             policy_i,
  input  logic             q_valid_i,
  input  logic [AddrW-1:0] q_addr_i,
  output logic             q_pop_o,
  output logic             done_o,
  output logic [PaW-1:0]   phys_addr_o,
  output logic             tlb_hit_o,
  output logic             page_fault_o,
  output logic             evicted_valid_o,
  output logic [EvW-1:0]   evicted_page_o
);

  localparam int unsigned TW  = $clog2(TLB_ENTRIES);
  localparam int unsigned PW  = $clog2(PAGE_COUNT);
  localparam int unsigned FW  = $clog2(FRAME_COUNT);
  localparam int unsigned HPW = AddrW - OFFSET_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_PT    = 3'd2;
  localparam logic [2:0] S_LRU   = 3'd3;
  localparam logic [2:0] S_VICT  = 3'd4;
  localparam logic [2:0] S_OWN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_ORD   = 3'd7;

  logic [2:0] st_q;

  // TLB in flops
  logic [PW-1:0]          tag_q  [TLB_ENTRIES];
  logic [FW-1:0]          tfr_q  [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tv_q;
  logic [TW-1:0]          fill_q;

  // page table memory with valid bits
  logic [FW-1:0]         pf_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] pv_q;
  logic [FW-1:0]         pf_rd_q;
  // frame owner memory, FIFO slots memory
  logic [PW-1:0] own_mem [FRAME_COUNT];
  logic [PW-1:0] own_rd_q;
  logic [FW-1:0] fq_mem [FRAME_COUNT];
  logic [FW-1:0] fq_rd_q;
  logic [FW-1:0] head_q, tail_q;
  logic [FW:0]   fcnt_q, used_q;
  // stamps: memory with registered read, valid bits make unwritten stamps zero
  logic [31:0]            st_mem [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] sv_q;
  logic [31:0]            st_rd_q;
  logic                   sv_rd_q;
  logic [31:0]            st_val;
  logic [31:0]            clk_cnt_q;
  logic [FW:0]            scan_q, scan_m1;
  logic [FW-1:0]          best_q;
  logic [31:0]            best_st_q;

  logic [PW-1:0]           page_q;
  logic [OFFSET_WIDTH-1:0] off_q;
  logic [FW-1:0]           frame_q;
  logic hit_q, fault_q, ev_q;
  logic [PW-1:0] evp_q;

  logic [HPW-1:0] hp;
  logic [PW-1:0]  pg;
  assign hp = q_addr_i[AddrW-1:OFFSET_WIDTH];
  assign pg = PW'(hp % PAGE_COUNT);

  assign st_val  = sv_rd_q ? st_rd_q : 32'd0;
  assign scan_m1 = scan_q - 1'b1;

  // lowest matching TLB entry
  logic          m_hit;
  logic [FW-1:0] m_fr;
  always_comb begin
    m_hit = 1'b0;
    m_fr  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tv_q[i] && tag_q[i] == page_q) begin
        m_hit = 1'b1;
        m_fr  = tfr_q[i];
      end
    end
  end

  assign q_pop_o = (st_q == S_IDLE) && q_valid_i;

  logic [31:0] nclk;
  assign nclk = clk_cnt_q + 32'd1;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      page_q <= pg;
      off_q  <= q_addr_i[OFFSET_WIDTH-1:0];
    end
    pf_rd_q  <= pf_mem[page_q];
    fq_rd_q  <= fq_mem[head_q];
    own_rd_q <= own_mem[frame_q];
    st_rd_q  <= st_mem[scan_q[FW-1:0]];
    sv_rd_q  <= sv_q[scan_q[FW-1:0]];
    if (st_q == S_DONE) st_mem[frame_q] <= nclk;
    if (st_q == S_DONE && fault_q) begin
      pf_mem[page_q]   <= frame_q;
      own_mem[frame_q] <= page_q;
      if (fcnt_q < (FW+1)'(FRAME_COUNT)) fq_mem[tail_q] <= frame_q;
    end
    if (st_q == S_DONE && !hit_q) begin
      tag_q[fill_q] <= page_q;
      tfr_q[fill_q] <= frame_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      tv_q      <= '0;
      fill_q    <= '0;
      pv_q      <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      fcnt_q    <= '0;
      used_q    <= '0;
      clk_cnt_q <= '0;
      sv_q      <= '0;
      done_o    <= 1'b0;
      hit_q     <= 1'b0;
      fault_q   <= 1'b0;
      ev_q      <= 1'b0;
      evp_q     <= '0;
      frame_q   <= '0;
      scan_q    <= '0;
      best_q    <= '0;
      best_st_q <= '0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        S_IDLE: if (q_valid_i) st_q <= S_LOOK;
        S_LOOK: begin
          hit_q   <= m_hit;
          frame_q <= m_fr;
          fault_q <= 1'b0;
          ev_q    <= 1'b0;
          evp_q   <= '0;
          st_q    <= m_hit ? S_DONE : S_PT;
        end
        S_PT: begin
          if (pv_q[page_q]) begin
            frame_q <= pf_rd_q;
            st_q    <= S_DONE;
          end else begin
            fault_q <= 1'b1;
            if (used_q < (FW+1)'(FRAME_COUNT)) begin
              frame_q <= used_q[FW-1:0];
              used_q  <= used_q + 1'b1;
              st_q    <= S_DONE;
            end else if (policy_i == PolicyLru) begin
              scan_q <= '0;
              st_q   <= S_LRU;
            end else begin
              st_q <= S_VICT;
            end
          end
        end
        S_LRU: begin
          // read data is registered, so it belongs to the previous scan address
          if (scan_q != '0) begin
            if (scan_q == (FW+1)'(1) || st_val < best_st_q) begin
              best_q    <= scan_m1[FW-1:0];
              best_st_q <= st_val;
            end
          end
          if (scan_q == (FW+1)'(FRAME_COUNT)) st_q <= S_VICT;
          scan_q <= scan_q + 1'b1;
        end
        S_VICT: begin
          if (policy_i == PolicyLru) begin
            frame_q <= best_q;
          end else if (fcnt_q == '0) begin
            frame_q <= '0;
          end else begin
            frame_q <= fq_rd_q;
            head_q  <= (head_q == FW'(FRAME_COUNT - 1)) ? '0 : head_q + 1'b1;
            fcnt_q  <= fcnt_q - 1'b1;
          end
          st_q <= S_ORD;
        end
        S_ORD: begin
          // owner read of the victim frame in flight
          st_q <= S_OWN;
        end
        S_OWN: begin
          st_q <= S_DONE;
        end
        S_DONE: begin
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase

      // eviction: own_rd_q valid in S_OWN (frame_q set in S_VICT, read in S_ORD)
      if (st_q == S_OWN) begin
        ev_q  <= 1'b1;
        evp_q <= own_rd_q;
        pv_q[own_rd_q] <= 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++)
          if (tag_q[i] == own_rd_q) tv_q[i] <= 1'b0;
      end

      if (st_q == S_DONE) begin
        done_o        <= 1'b1;
        clk_cnt_q     <= nclk;
        sv_q[frame_q] <= 1'b1;
        if (fault_q) begin
          pv_q[page_q] <= 1'b1;
          if (fcnt_q < (FW+1)'(FRAME_COUNT)) begin
            tail_q <= (tail_q == FW'(FRAME_COUNT - 1)) ? '0 : tail_q + 1'b1;
            fcnt_q <= fcnt_q + 1'b1;
          end
        end
        if (!hit_q) begin
          tv_q[fill_q] <= 1'b1;
          fill_q       <= (fill_q == TW'(TLB_ENTRIES - 1)) ? '0 : fill_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_DONE) begin
      phys_addr_o     <= PaW'({frame_q, off_q});
      tlb_hit_o       <= hit_q;
      page_fault_o    <= fault_q;
      evicted_valid_o <= ev_q;
      evicted_page_o  <= EvW'(evp_q);
    end
  end

endmodule

>>> hw/rtl/tlbpt_checker.sv
module tlbpt_checker import tlbpt_pkg::*; (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy_o,
  input logic           done_o,
  input logic           tlb_hit_o,
  input logic           page_fault_o,
  input logic           evicted_valid_o,
  input logic [EvW-1:0] evicted_page_o
);

  a_hit_nofault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(tlb_hit_o && page_fault_o)) else $error("hit with fault");
  a_ev_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_valid_o |-> page_fault_o) else $error("evict w/o fault");
  a_ev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !evicted_valid_o |-> evicted_page_o == '0) else $error("stray page");
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back results");
  a_busy_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(busy_o)) else $error("busy unknown");

endmodule

bind tlb_page_table_translator_unit tlbpt_checker u_chk (
  .clk_i, .rst_ni, .busy_o, .done_o, .tlb_hit_o, .page_fault_o,
  .evicted_valid_o, .evicted_page_o
);
